// ===== sv/drit_pkg.sv =====
// Package with shared constants and types for the delayed repeat interval timer.
package drit_pkg;

  localparam int unsigned MAX_FIRES_PER_STEP = 16;
  localparam int unsigned FIRE_CNT_W = $clog2(MAX_FIRES_PER_STEP + 1);
  localparam logic [31:0] REPEAT_FOREVER = 32'hFFFF_FFFE;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_DELAY    = 2'd1,
    CFG_REPEAT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic cfg_en;
    logic load_step;
    logic do_fire;
  } ctrl_cmd_t;

  typedef struct packed {
    logic active;
    logic fire_now;
    logic last;
  } dp_status_t;

endpackage

// ===== sv/drit_ctrl.sv =====
// Controller state machine that sequences step intake and fire emission.
module drit_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 cfg_ready_o,
  input  drit_pkg::dp_status_t status_i,
  output drit_pkg::ctrl_cmd_t  cmd_o
);

  drit_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drit_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    cfg_ready_o       = 1'b0;
    out_valid_o       = 1'b0;
    cmd_o.cfg_en      = 1'b0;
    cmd_o.load_step   = 1'b0;
    cmd_o.do_fire     = 1'b0;
    unique case (state_q)
      drit_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cfg_ready_o  = !in_valid_i;
        cmd_o.cfg_en = !in_valid_i;
        if (in_valid_i) begin
          cmd_o.load_step = 1'b1;
          if (status_i.active) begin
            state_d = drit_pkg::ST_EVAL;
          end
        end
      end
      drit_pkg::ST_EVAL: begin
        if (status_i.fire_now) begin
          cmd_o.do_fire = 1'b1;
          state_d       = drit_pkg::ST_EMIT;
        end else begin
          state_d = drit_pkg::ST_IDLE;
        end
      end
      drit_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) begin
            state_d = drit_pkg::ST_IDLE;
          end else begin
            cmd_o.do_fire = 1'b1;
          end
        end
      end
      default: begin
        state_d = drit_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/drit_dp.sv =====
// Datapath with timer registers, elapsed accumulator, fire counter and result registers.
module drit_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  drit_pkg::ctrl_cmd_t  cmd_i,
  output drit_pkg::dp_status_t status_o,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [31:0]          step_time_i,
  output logic [31:0]          fire_amount_o,
  output logic                 finished_o,
  output logic                 last_fire_o
);

  logic [31:0] interval_q;
  logic [31:0] delay_q;
  logic [31:0] repeat_q;
  logic [31:0] acc_q;
  logic [31:0] cnt_q;
  logic        armed_q;
  logic        delay_pend_q;
  logic        stopped_q;
  logic [drit_pkg::FIRE_CNT_W-1:0] nfire_q;
  logic [31:0] amount_q;
  logic        fin_q;
  logic        last_q;

  logic [32:0] sum;
  logic [31:0] acc_sat;
  logic [31:0] iv;
  logic [31:0] amt;
  logic [31:0] acc_new;
  logic        fire_now;
  logic        more;
  logic [31:0] cnt_new;
  logic        fin;
  logic        room;
  logic        cfg_hit;

  assign sum     = {1'b0, acc_q} + {1'b0, step_time_i};
  assign acc_sat = sum[32] ? drit_pkg::TIME_MAX : sum[31:0];
  assign iv      = (interval_q != 32'd0) ? interval_q : acc_q;
  assign cnt_new = (cnt_q == drit_pkg::TIME_MAX) ? cnt_q : cnt_q + 32'd1;
  assign fin     = (repeat_q != drit_pkg::REPEAT_FOREVER) && (cnt_new > repeat_q);
  assign room    = nfire_q < drit_pkg::FIRE_CNT_W'(drit_pkg::MAX_FIRES_PER_STEP - 1);
  assign cfg_hit = (cfg_index_i == drit_pkg::CFG_INTERVAL) ||
                   (cfg_index_i == drit_pkg::CFG_DELAY) ||
                   (cfg_index_i == drit_pkg::CFG_REPEAT);

  always_comb begin
    if (delay_pend_q) begin
      amt      = delay_q;
      fire_now = acc_q >= delay_q;
      acc_new  = acc_q - delay_q;
      more     = !fin && room && ((interval_q == 32'd0) || (acc_new >= interval_q));
    end else begin
      amt      = iv;
      fire_now = acc_q >= iv;
      acc_new  = acc_q - iv;
      more     = !fin && room && (acc_new != 32'd0) && (acc_new >= iv);
    end
  end

  assign status_o.active   = armed_q && !stopped_q;
  assign status_o.fire_now = fire_now;
  assign status_o.last     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= '0;
      delay_q      <= '0;
      repeat_q     <= '0;
      acc_q        <= '0;
      cnt_q        <= '0;
      armed_q      <= 1'b0;
      delay_pend_q <= 1'b0;
      stopped_q    <= 1'b0;
      nfire_q      <= '0;
      last_q       <= 1'b0;
    end else if (cmd_i.cfg_en && cfg_valid_i && cfg_hit) begin
      unique case (cfg_index_i)
        drit_pkg::CFG_INTERVAL: interval_q <= cfg_data_i;
        drit_pkg::CFG_DELAY:    delay_q    <= cfg_data_i;
        drit_pkg::CFG_REPEAT:   repeat_q   <= cfg_data_i;
        default: ;
      endcase
      acc_q     <= '0;
      cnt_q     <= '0;
      armed_q   <= 1'b0;
      stopped_q <= 1'b0;
      if (cfg_index_i == drit_pkg::CFG_DELAY) begin
        delay_pend_q <= cfg_data_i != 32'd0;
      end else begin
        delay_pend_q <= delay_q != 32'd0;
      end
    end else if (cmd_i.load_step) begin
      if (!stopped_q) begin
        if (!armed_q) begin
          armed_q <= 1'b1;
          acc_q   <= '0;
          cnt_q   <= '0;
        end else begin
          acc_q   <= acc_sat;
          nfire_q <= '0;
        end
      end
    end else if (cmd_i.do_fire) begin
      acc_q        <= acc_new;
      cnt_q        <= cnt_new;
      delay_pend_q <= 1'b0;
      nfire_q      <= nfire_q + drit_pkg::FIRE_CNT_W'(1);
      last_q       <= !more;
      if (fin) begin
        stopped_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_fire) begin
      amount_q <= amt;
      fin_q    <= fin;
    end
  end

  assign fire_amount_o = amount_q;
  assign finished_o    = fin_q;
  assign last_fire_o   = last_q;

endmodule

// ===== sv/delayed_repeat_interval_timer.sv =====
// Top level of the delayed repeat interval timer.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o   step_time_i
//   out      output     out_valid_o/out_ready_i fire_amount_o, finished_o, last_fire_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A step is accepted in ST_IDLE and, when the timer is armed and running, is tested
// for its first fire in ST_EVAL. Each further fire is produced in the cycle its
// predecessor is taken; no new step is accepted until a step's last fire is taken.
// Throughput is set by the single compare and subtract unit on the accumulator.
// Register writes are taken only when idle and no step is offered.
// Reset clears all but the amount_q and fin_q registers; output stalls hold the fire.
module delayed_repeat_interval_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] step_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] fire_amount_o,
  output logic        finished_o,
  output logic        last_fire_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  drit_pkg::ctrl_cmd_t  cmd;
  drit_pkg::dp_status_t status;

  drit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  drit_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .step_time_i   (step_time_i),
    .fire_amount_o (fire_amount_o),
    .finished_o    (finished_o),
    .last_fire_o   (last_fire_o)
  );

endmodule

// ===== verif/tb_drit_fire_checker.sv =====
// Checker for the delayed repeat interval timer: predicts fires per step and compares them.
module tb_drit_fire_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] step_time_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] fire_amount_i,
  input  logic        finished_i,
  input  logic        last_fire_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          fires_due_o
);

  typedef struct packed {
    logic [31:0] amount;
    logic        finished;
    logic        last;
  } fire_t;

  fire_t       fires_due[$];
  fire_t       head;
  logic [31:0] interval_q;
  logic [31:0] delay_q;
  logic [31:0] repeat_q;
  logic [31:0] acc_q;
  logic [31:0] count_q;
  logic        started_q;
  logic        delay_pend_q;
  logic        stopped_q;

  task automatic rearm_timer();
    acc_q        = '0;
    started_q    = 1'b0;
    count_q      = '0;
    stopped_q    = 1'b0;
    delay_pend_q = (delay_q != '0);
  endtask

  task automatic count_fire(output logic fin);
    if (count_q != drit_pkg::TIME_MAX) count_q = count_q + 32'd1;
    fin = (repeat_q != drit_pkg::REPEAT_FOREVER) && (count_q > repeat_q);
    if (fin) stopped_q = 1'b1;
  endtask

  task automatic queue_fire(input logic [31:0] amount, input logic fin);
    fire_t f;
    f.amount   = amount;
    f.finished = fin;
    f.last     = 1'b0;
    fires_due  = {fires_due, f};
  endtask

  task automatic predict_fires(input logic [31:0] step);
    logic [31:0] iv;
    logic        fin;
    int          n;
    n = 0;
    if (stopped_q) return;
    if (!started_q) begin
      started_q = 1'b1;
      acc_q     = '0;
      count_q   = '0;
      return;
    end
    acc_q = (acc_q > drit_pkg::TIME_MAX - step) ? drit_pkg::TIME_MAX : acc_q + step;
    if (delay_pend_q) begin
      if (acc_q < delay_q) return;
      acc_q        = acc_q - delay_q;
      delay_pend_q = 1'b0;
      count_fire(fin);
      queue_fire(delay_q, fin);
      n++;
    end
    if (!stopped_q) begin
      iv = (interval_q != '0) ? interval_q : acc_q;
      while (acc_q >= iv && n < drit_pkg::MAX_FIRES_PER_STEP) begin
        acc_q = acc_q - iv;
        count_fire(fin);
        queue_fire(iv, fin);
        n++;
        if (fin || acc_q == '0) break;
      end
    end
    if (n > 0) fires_due[fires_due.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q = '0;
      delay_q    = '0;
      repeat_q   = '0;
      rearm_timer();
      fires_due.delete();
      fail_count_o = 0;
      fires_due_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (fires_due.size() == 0) begin
          $error("fire transaction with no fire expected: amount %h", fire_amount_i);
          fail_count_o++;
        end else begin
          head = fires_due.pop_front();
          if (fire_amount_i !== head.amount) begin
            $error("fire_amount mismatch: expected %h, actual %h", head.amount, fire_amount_i);
            fail_count_o++;
          end
          if (finished_i !== head.finished) begin
            $error("finished mismatch: expected %b, actual %b", head.finished, finished_i);
            fail_count_o++;
          end
          if (last_fire_i !== head.last) begin
            $error("last_fire mismatch: expected %b, actual %b", head.last, last_fire_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          drit_pkg::CFG_INTERVAL: begin
            interval_q = cfg_data_i;
            rearm_timer();
          end
          drit_pkg::CFG_DELAY: begin
            delay_q = cfg_data_i;
            rearm_timer();
          end
          drit_pkg::CFG_REPEAT: begin
            repeat_q = cfg_data_i;
            rearm_timer();
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_fires(step_time_i);
      fires_due_o = fires_due.size();
    end
  end

endmodule

// ===== verif/tb_delayed_repeat_interval_timer.sv =====
// Testbench top for the delayed repeat interval timer: stimulus, pacing and verdict.
module tb_delayed_repeat_interval_timer;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int          SEGMENTS       = 4;
  localparam int          SEG_STEPS      = 25;
  localparam logic [1:0]  CFG_BAD_IDX    = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] step_time_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] fire_amount_o;
  logic        finished_o;
  logic        last_fire_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  int          fail_count;
  int          fires_due;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_reqs;
  logic [31:0] cur_interval;
  logic [31:0] step_seq[$];

  delayed_repeat_interval_timer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .step_time_i   (step_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .fire_amount_o (fire_amount_o),
    .finished_o    (finished_o),
    .last_fire_o   (last_fire_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  tb_drit_fire_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .step_time_i   (step_time_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .fire_amount_i (fire_amount_o),
    .finished_i    (finished_o),
    .last_fire_i   (last_fire_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .fires_due_o   (fires_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : rx_pacing
    int hold_left;
    int hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Entered and left at a falling edge; valid is left high for the next step.
  task automatic send_step(input logic [31:0] step);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    step_time_i <= step;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Waits until every expected fire has come, then lets a silent step finish.
  task automatic drain_fires();
    while (fires_due != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [31:0] iv, input logic [31:0] dl,
                               input logic [31:0] rp);
    write_reg(drit_pkg::CFG_INTERVAL, iv);
    write_reg(drit_pkg::CFG_DELAY, dl);
    write_reg(drit_pkg::CFG_REPEAT, rp);
    cfg_valid_i  <= 1'b0;
    cur_interval = iv;
  endtask

  task automatic play_steps();
    foreach (step_seq[k]) send_step(step_seq[k]);
    in_valid_i <= 1'b0;
    drain_fires();
  endtask

  task automatic random_setting();
    drit_pkg::cfg_idx_e order[3];
    logic [31:0]        vals[3];
    int                 first;
    case ($urandom_range(0, 5))
      0:       vals[0] = '0;
      1:       vals[0] = $urandom_range(1, 16);
      2, 3:    vals[0] = $urandom_range(1, 'h3FFFF);
      4:       vals[0] = $urandom;
      default: vals[0] = drit_pkg::TIME_MAX;
    endcase
    case ($urandom_range(0, 3))
      0, 1:    vals[1] = '0;
      2:       vals[1] = $urandom_range(1, 'h3FFFF);
      default: vals[1] = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: vals[2] = drit_pkg::REPEAT_FOREVER;
      3:       vals[2] = $urandom_range(0, 40);
      4:       vals[2] = drit_pkg::TIME_MAX;
      default: vals[2] = $urandom;
    endcase
    order[0] = drit_pkg::CFG_INTERVAL;
    order[1] = drit_pkg::CFG_DELAY;
    order[2] = drit_pkg::CFG_REPEAT;
    first = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      write_reg(order[(first + k) % 3], vals[(first + k) % 3]);
    end
    if ($urandom_range(0, 3) == 0) write_reg(CFG_BAD_IDX, $urandom);
    cfg_valid_i  <= 1'b0;
    cur_interval = vals[0];
  endtask

  function automatic logic [31:0] random_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return drit_pkg::TIME_MAX;
      2, 3:    return $urandom;
      default: begin
        if (cur_interval != '0 && cur_interval <= 32'h03FF_FFFF) begin
          return $urandom_range(0, cur_interval * 3);
        end else begin
          return $urandom_range(0, 'h3FFFF);
        end
      end
    endcase
  endfunction

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    step_time_i  = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_reqs    = 0;
    cur_interval = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset registers: zero interval fires the whole accumulator once and stops.
    step_seq = '{32'h0, drit_pkg::TIME_MAX, 32'h5};
    play_steps();
    // An unknown register index must not re-arm a stopped timer.
    write_reg(CFG_BAD_IDX, 32'h0001_2345);
    cfg_valid_i <= 1'b0;
    step_seq = '{32'h7};
    play_steps();

    // Full-scale delay, then the per-step fire cap with the surplus carried over.
    apply_setting(32'h1, drit_pkg::TIME_MAX, drit_pkg::REPEAT_FOREVER);
    step_seq = '{32'h0, drit_pkg::TIME_MAX, drit_pkg::TIME_MAX, 32'h0};
    play_steps();

    // Accumulator saturation with a repeat count that never completes.
    apply_setting(32'h0001_0000, 32'h0, drit_pkg::TIME_MAX);
    step_seq = '{32'h1234, drit_pkg::TIME_MAX, drit_pkg::TIME_MAX, 32'h8000};
    play_steps();

    // Delay not yet reached, then delay and interval fires until the repeats run out.
    apply_setting(32'h8000, 32'h0001_8000, 32'd3);
    step_seq = '{32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000};
    play_steps();

    // Zero interval after a delay fire that empties the accumulator.
    apply_setting(32'h0, 32'h5, 32'd2);
    step_seq = '{32'h0, 32'h5, 32'h7, 32'h3};
    play_steps();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct = 51;
        end
        1: begin
          tx_idle_pct = 51;
          rx_idle_pct = 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        if (phase == 0 && seg == 1) begin
          // A short interval that never stops keeps fires coming during the hold.
          apply_setting(32'h100, 32'h0, drit_pkg::REPEAT_FOREVER);
          hold_reqs++;
        end else begin
          random_setting();
        end
        for (int i = 0; i < SEG_STEPS; i++) begin
          if ($urandom_range(0, 29) == 0) begin
            in_valid_i <= 1'b0;
            drain_fires();
          end
          send_step(random_step());
        end
        in_valid_i <= 1'b0;
        drain_fires();
      end
    end

    if (fail_count == 0 && fires_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/drit_pkg.sv
sv/drit_ctrl.sv
sv/drit_dp.sv
sv/delayed_repeat_interval_timer.sv
verif/tb_drit_fire_checker.sv
verif/tb_delayed_repeat_interval_timer.sv
